>>> rtl/core/chm_pkg.sv
// Shared constants and types for the chained hash map.
package chm_pkg;
	localparam int BUCKETS_DEF = 128;
	localparam int POOL_NODES_DEF = 256;
	localparam int KEY_W = 31;
	localparam int VAL_W = 32;
	localparam int OP_W = 2;
	localparam int ST_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_GET = 2'd0,
		OP_PUT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_RSVD = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL = 2'd2
	} status_t;
endpackage

>>> rtl/core/chained_hash_map_top.sv
// Top level of the chained hash map: sequencer, node pool and bucket heads.
//
//  channel  | signals                       | handshake
//  request  | operation, key, value         | start && !busy
//  result   | status, read_value            | done strobe, one cycle, no stall
//
// Busy covers the head read and the walk along the chain; a miss, an append or a
// remove hit adds its own states, and a reserved code goes from the head state to done.
// done follows in the first idle cycle; the single-port node memory read sets the pace.
// After reset one sweep builds the free list over POOL_NODES nodes and clears the
// BUCKETS heads (run together, over the larger of the two); busy stays high meanwhile.
// The result cannot be stalled; start is taken in the same cycle as done.
module chained_hash_map_top #(
	parameter int BUCKETS = chm_pkg::BUCKETS_DEF,
	parameter int POOL_NODES = chm_pkg::POOL_NODES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [chm_pkg::OP_W-1:0] operation,
	input  logic [chm_pkg::KEY_W-1:0] key,
	input  logic signed [chm_pkg::VAL_W-1:0] value,
	output logic busy,
	output logic done,
	output logic [chm_pkg::ST_W-1:0] status,
	output logic signed [chm_pkg::VAL_W-1:0] read_value
);
	localparam int NW = $clog2(POOL_NODES + 1);
	localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int CW = (NW > BW + 1) ? NW : BW + 1;
	localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_HEAD, S_RD, S_CMP, S_APPEND, S_UNLINK, S_FREE, S_DONE
	} state_t;

	// Memories: keys, values, links, heads
	logic [chm_pkg::KEY_W-1:0] keys_mem [POOL_NODES];
	logic [chm_pkg::VAL_W-1:0] vals_mem [POOL_NODES];
	logic [NW-1:0] links_mem [POOL_NODES];
	logic [NW-1:0] heads_mem [BUCKETS];

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [chm_pkg::OP_W-1:0] op_q;
	logic [chm_pkg::KEY_W-1:0] key_q;
	logic [chm_pkg::VAL_W-1:0] val_q;
	logic [BW-1:0] bkt_q;
	logic [NW-1:0] cur_q, prev_q, free_q, nxt_q;
	logic [CW-1:0] steps_q;
	logic [chm_pkg::KEY_W-1:0] rkey_q;
	logic [chm_pkg::VAL_W-1:0] rval_q;
	logic [NW-1:0] rlink_q, rhead_q;
	logic [chm_pkg::ST_W-1:0] status_q;
	logic [chm_pkg::VAL_W-1:0] rv_q;
	logic done_q;

	// Memory port controls
	logic nd_we, ln_we, hd_we, vl_we;
	logic [AW-1:0] nd_addr, ln_addr, rd_addr;
	logic [NW-1:0] ln_wdata, hd_wdata;
	logic [BW-1:0] hd_addr;

	logic [BW-1:0] bkt_in;
	logic key_hit;
	assign bkt_in = BW'(key % BUCKETS);
	assign key_hit = (rkey_q == key_q);
	assign rd_addr = cur_q[AW-1:0];

	always_ff @(posedge clk) begin
		rkey_q <= keys_mem[rd_addr];
		rval_q <= vals_mem[rd_addr];
		rlink_q <= links_mem[rd_addr];
		rhead_q <= heads_mem[bkt_q];
		if (nd_we) begin
			keys_mem[nd_addr] <= key_q;
		end
		if (vl_we) begin
			vals_mem[nd_addr] <= val_q;
		end
		if (ln_we) begin
			links_mem[ln_addr] <= ln_wdata;
		end
		if (hd_we) begin
			heads_mem[hd_addr] <= hd_wdata;
		end
	end

	// Write port decode per state
	always_comb begin
		nd_we = 1'b0;
		vl_we = 1'b0;
		ln_we = 1'b0;
		hd_we = 1'b0;
		nd_addr = cur_q[AW-1:0];
		ln_addr = cur_q[AW-1:0];
		ln_wdata = NIL;
		hd_addr = bkt_q;
		hd_wdata = NIL;
		unique case (state_q)
			S_INIT: begin
				ln_we = (cnt_q < CW'(POOL_NODES));
				ln_addr = cnt_q[AW-1:0];
				ln_wdata = NW'(cnt_q) + NW'(1);
				hd_we = (cnt_q < CW'(BUCKETS));
				hd_addr = cnt_q[BW-1:0];
			end
			S_CMP: begin
				// overwrite on put hit
				if (op_q == chm_pkg::OP_PUT && key_hit) begin
					vl_we = 1'b1;
				end
			end
			S_APPEND: begin
				// new node at free head; cnt_q[0] selects tail link write
				if (cnt_q[0] == 1'b0) begin
					nd_we = 1'b1;
					vl_we = 1'b1;
					nd_addr = free_q[AW-1:0];
					ln_we = 1'b1;
					ln_addr = free_q[AW-1:0];
					ln_wdata = NIL;
				end else if (prev_q == NIL) begin
					hd_we = 1'b1;
					hd_wdata = nxt_q;
				end else begin
					ln_we = 1'b1;
					ln_addr = prev_q[AW-1:0];
					ln_wdata = nxt_q;
				end
			end
			S_UNLINK: begin
				if (prev_q == NIL) begin
					hd_we = 1'b1;
					hd_wdata = nxt_q;
				end else begin
					ln_we = 1'b1;
					ln_addr = prev_q[AW-1:0];
					ln_wdata = nxt_q;
				end
			end
			S_FREE: begin
				ln_we = 1'b1;
				ln_addr = cur_q[AW-1:0];
				ln_wdata = free_q;
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q <= '0;
			free_q <= '0;
			done_q <= 1'b0;
			op_q <= '0;
			cur_q <= NIL;
			prev_q <= NIL;
			nxt_q <= NIL;
			steps_q <= '0;
			bkt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'((POOL_NODES > BUCKETS ? POOL_NODES : BUCKETS) - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q <= operation;
						key_q <= key;
						val_q <= value;
						bkt_q <= bkt_in;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					// head read lands in rhead_q after this cycle
					cur_q <= NIL;
					prev_q <= NIL;
					steps_q <= '0;
					cnt_q <= '0;
					if (op_q == chm_pkg::OP_RSVD) begin
						status_q <= chm_pkg::ST_ABSENT;
						rv_q <= '1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					// pick next node; issue its read
					if (cnt_q[0] == 1'b0) begin
						cnt_q[0] <= 1'b1;
						cur_q <= rhead_q;
						if (rhead_q >= NIL) begin
							state_q <= S_CMP;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (cur_q < NIL && steps_q < CW'(POOL_NODES) && key_hit) begin
						status_q <= chm_pkg::ST_OK;
						rv_q <= (op_q == chm_pkg::OP_GET) ? rval_q : '1;
						nxt_q <= rlink_q;
						if (op_q == chm_pkg::OP_REMOVE) begin
							state_q <= S_UNLINK;
						end else begin
							state_q <= S_DONE;
						end
					end else if (cur_q < NIL && steps_q < CW'(POOL_NODES)) begin
						prev_q <= cur_q;
						cur_q <= rlink_q;
						steps_q <= steps_q + CW'(1);
						state_q <= (rlink_q < NIL) ? S_RD : S_CMP;
					end else begin
						// chain exhausted; prev_q is the tail
						rv_q <= '1;
						if (op_q != chm_pkg::OP_PUT) begin
							status_q <= chm_pkg::ST_ABSENT;
							state_q <= S_DONE;
						end else if (free_q >= NIL) begin
							status_q <= chm_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							status_q <= chm_pkg::ST_OK;
							cur_q <= free_q;
							nxt_q <= free_q;
							cnt_q <= '0;
							state_q <= S_APPEND;
						end
					end
				end
				S_APPEND: begin
					// first step writes node; second step links it; free head read via cur_q
					if (cnt_q[0] == 1'b0) begin
						cnt_q[0] <= 1'b1;
					end else begin
						free_q <= rlink_q;
						state_q <= S_DONE;
					end
				end
				S_UNLINK: begin
					state_q <= S_FREE;
				end
				S_FREE: begin
					free_q <= cur_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_INIT;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign read_value = rv_q;
endmodule

>>> rtl/core/chm_checker.sv
// Port-level checker for the chained hash map, bound to the top level.
module chm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [chm_pkg::ST_W-1:0] status,
	input logic signed [chm_pkg::VAL_W-1:0] read_value
);
	// accepted item locks the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy low after accept");
	// strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	// result shows while busy drops
	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy during done");
	// non-success results carry all ones
	a_rv_ones: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != chm_pkg::ST_OK |-> read_value == -32'sd1)
		else $error("read_value not -1 on miss");
	// status code range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3) else $error("bad status");
endmodule

bind chained_hash_map_top chm_checker u_chm_checker (.*);
